// ===== hw/rtl/pci_pkg.sv =====
// Shared types, constants and codes for the perceptron controller inference block.
// Used by pci_act, pci_lane and perceptron_controller_inference_top; no dependencies.
`timescale 1ns / 1ps

package pci_pkg;

  // network shape
  localparam int unsigned HIDDEN_GENES       = 4;
  localparam int unsigned BELL_GROUP_GENES   = 1;
  localparam int unsigned SCURVE_GROUP_GENES = 1;
  localparam int unsigned STIMULUS_COUNT     = 8;
  localparam int unsigned HIDDEN_TOTAL       = 4 * HIDDEN_GENES;

  // lanes and weight banks
  localparam int unsigned LANES      = 4;
  localparam int unsigned LANE_W     = 2;
  localparam int unsigned ROUND_W    = 2;
  localparam int unsigned HID_SLOTS  = 16;
  localparam int unsigned HID_IDX_W  = 4;
  localparam int unsigned BANK_DEPTH = 128;
  localparam int unsigned BANK_AW    = 7;
  localparam int unsigned STEP_W     = 5;
  localparam int unsigned HID_STEPS  = STIMULUS_COUNT + 1;
  localparam int unsigned OUT_STEPS  = HIDDEN_TOTAL + 1;

  // fixed point constants
  localparam logic signed [31:0] ONE_Q  = 32'sd65536;
  localparam logic signed [31:0] FIVE_Q = 32'sd327680;
  localparam logic signed [39:0] CURVE_HALF = 40'sd500;
  localparam logic signed [39:0] S_SLOPE    = 40'sd150;
  localparam logic signed [39:0] DIV_OFFSET = 40'sd524288000;
  localparam logic signed [22:0] DIV_BACK   = 23'sd524288;
  localparam logic signed [22:0] S_BASE     = 23'sd32768;
  localparam logic signed [22:0] BELL_BASE  = 23'sd65536;
  localparam logic [30:0]        RECIP_1000 = 31'd1099511628;

  // operation codes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_EVAL  = 1'b1;

  typedef enum logic [1:0] {
    ACT_BELL   = 2'd0,
    ACT_SCURVE = 2'd1,
    ACT_RELU   = 2'd2
  } act_kind_e;

  typedef struct packed {
    logic               operation;
    logic [8:0]         weight_address;
    logic signed [31:0] weight_value;
    logic signed [31:0] food_strength;
    logic signed [31:0] food_direction;
    logic signed [31:0] danger_strength;
    logic signed [31:0] danger_direction;
    logic signed [31:0] wall_strength;
    logic signed [31:0] wall_direction;
    logic signed [31:0] food_smell;
    logic signed [31:0] danger_smell;
  } in_item_t;

  typedef struct packed {
    logic [16:0] left_drive;
    logic [16:0] right_drive;
  } out_item_t;

  // per-step control broadcast to the lanes
  typedef struct packed {
    logic               issue;
    logic               first;
    logic [BANK_AW-1:0] rd_addr;
    logic signed [31:0] x;
  } mac_ctl_t;

  typedef struct packed {
    logic               we;
    logic [BANK_AW-1:0] addr;
    logic [31:0]        data;
  } wr_req_t;

endpackage

// ===== hw/rtl/perceptron_controller_inference_top.sv =====
// Top level of the two-layer perceptron controller: sequencer, lanes and merge.
// Depends on pci_pkg and pci_lane.
`timescale 1ns / 1ps

// A write item stores one weight word. In an evaluate item four lanes each own a
// quarter of the weight store and compute four hidden neurons side by side, nine
// reads of their bank per neuron through one multiply-accumulate, then a pipelined
// activation unit; two lanes then form the left and right outputs from the
// merged hidden values in 4*HIDDEN_GENES+1 steps plus activation. One evaluation
// is in flight at a time; a finished result waits in an output register while
// the next item is taken.
module perceptron_controller_inference_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  pci_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output pci_pkg::out_item_t out_item_o
);
  import pci_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MAC  = 4'b0010,
    ST_ACT  = 4'b0100,
    ST_OUT  = 4'b1000
  } state_e;

  state_e             state_q, state_d;
  logic               phase_q, phase_d;
  logic [ROUND_W-1:0] round_q, round_d;
  logic [STEP_W-1:0]  cnt_q, cnt_d;
  logic signed [31:0] stim_q [STIMULUS_COUNT];
  logic signed [31:0] hid_q [HID_SLOTS];
  logic [LANE_W-1:0]  sel_q [LANES];
  logic [LANE_W-1:0]  sel_d [LANES];
  logic               out_valid_q, out_valid_d;
  out_item_t          out_item_q;

  logic               accept;
  logic               do_write;
  logic               do_eval;
  logic [STEP_W-1:0]  nsteps;
  logic [STEP_W-1:0]  cnt_m1;
  logic               issue;
  logic               slot_free;
  logic               hid_done;
  logic               out_load;
  mac_ctl_t           ctl;
  wr_req_t            wr [LANES];
  logic [31:0]        rdata [LANES];
  logic signed [31:0] w_mux [LANES];
  logic               act_done [LANES];
  logic signed [31:0] act_res [LANES];
  logic               act_start;
  act_kind_e          act_kind;

  assign accept    = in_valid_i && (state_q == ST_IDLE);
  assign do_write  = accept && (in_item_i.operation == OP_WRITE);
  assign do_eval   = accept && (in_item_i.operation == OP_EVAL);
  assign nsteps    = phase_q ? STEP_W'(OUT_STEPS) : STEP_W'(HID_STEPS);
  assign cnt_m1    = cnt_q - STEP_W'(1);
  assign issue     = (state_q == ST_MAC) && (cnt_q < nsteps);
  assign slot_free = !out_valid_q || !out_stall_i;
  assign act_start = (state_q == ST_ACT) && (cnt_q == '0);
  assign hid_done  = (state_q == ST_ACT) && act_done[0] && !phase_q;
  assign out_load  = ((state_q == ST_ACT) && act_done[0] && phase_q && slot_free)
                     || ((state_q == ST_OUT) && slot_free);

  // step control broadcast: bias step multiplies by one
  always_comb begin
    ctl.issue = issue;
    ctl.first = (cnt_q == '0);
    if (phase_q) begin
      ctl.rd_addr = {3'b100, cnt_q[3:0]};
      ctl.x       = (cnt_q == '0) ? ONE_Q : hid_q[cnt_m1[HID_IDX_W-1:0]];
    end else begin
      ctl.rd_addr = {1'b0, round_q, cnt_q[3:0]};
      ctl.x       = (cnt_q == '0) ? ONE_Q : stim_q[cnt_m1[2:0]];
    end
  end

  // bank routing: hidden lanes read their own bank, output terms past 16 sit one bank up
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      sel_d[l] = LANE_W'(l);
    end
    if (phase_q) begin
      sel_d[0] = {1'b0, cnt_q[4]};
      sel_d[1] = {1'b1, cnt_q[4]};
    end
  end

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      w_mux[l] = $signed(rdata[sel_q[l]]);
    end
  end

  // activation choice per gene group
  always_comb begin
    if (phase_q) begin
      act_kind = ACT_SCURVE;
    end else if (32'(round_q) < BELL_GROUP_GENES) begin
      act_kind = ACT_BELL;
    end else if (32'(round_q) < BELL_GROUP_GENES + SCURVE_GROUP_GENES) begin
      act_kind = ACT_SCURVE;
    end else begin
      act_kind = ACT_RELU;
    end
  end

  // weight write steering by bank
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      wr[l].we   = do_write && (in_item_i.weight_address[5:4] == LANE_W'(l));
      wr[l].addr = {in_item_i.weight_address[8:6], in_item_i.weight_address[3:0]};
      wr[l].data = in_item_i.weight_value;
    end
  end

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    pci_lane u_lane (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .wr_i         (wr[g]),
      .ctl_i        (ctl),
      .w_i          (w_mux[g]),
      .rdata_o      (rdata[g]),
      .act_start_i  (act_start),
      .act_kind_i   (act_kind),
      .act_done_o   (act_done[g]),
      .act_result_o (act_res[g])
    );
  end

  // sequencer
  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    round_d     = round_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        if (do_eval) begin
          state_d = ST_MAC;
          phase_d = 1'b0;
          round_d = '0;
          cnt_d   = '0;
        end
      end
      ST_MAC: begin
        cnt_d = cnt_q + STEP_W'(1);
        if (cnt_q == nsteps + STEP_W'(1)) begin
          state_d = ST_ACT;
          cnt_d   = '0;
        end
      end
      ST_ACT: begin
        cnt_d = cnt_q + STEP_W'(1);
        if (act_done[0]) begin
          cnt_d = '0;
          if (phase_q) begin
            state_d = slot_free ? ST_IDLE : ST_OUT;
          end else begin
            state_d = ST_MAC;
            if (round_q == ROUND_W'(HIDDEN_GENES - 1)) begin
              phase_d = 1'b1;
            end else begin
              round_d = round_q + ROUND_W'(1);
            end
          end
        end
      end
      ST_OUT: begin
        if (slot_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= 1'b0;
      round_q     <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      round_q     <= round_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // stimuli capture, routing delay and merge of lane results
  always_ff @(posedge clk_i) begin
    if (do_eval) begin
      stim_q[0] <= in_item_i.food_strength;
      stim_q[1] <= in_item_i.food_direction;
      stim_q[2] <= in_item_i.danger_strength;
      stim_q[3] <= in_item_i.danger_direction;
      stim_q[4] <= in_item_i.wall_strength;
      stim_q[5] <= in_item_i.wall_direction;
      stim_q[6] <= in_item_i.food_smell;
      stim_q[7] <= in_item_i.danger_smell;
    end
    if (issue) begin
      for (int l = 0; l < LANES; l++) begin
        sel_q[l] <= sel_d[l];
      end
    end
    if (hid_done) begin
      for (int l = 0; l < LANES; l++) begin
        hid_q[{round_q, LANE_W'(l)}] <= act_res[l];
      end
    end
    if (out_load) begin
      out_item_q.left_drive  <= act_res[0][16:0];
      out_item_q.right_drive <= act_res[1][16:0];
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

`ifndef NO_ASSERTIONS
  a_done_in_act : assert property (@(posedge clk_i) disable iff (!rst_ni)
    act_done[0] |-> (state_q == ST_ACT))
    else $error("activation finished outside the activation state");

  a_eval_starts : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && (in_item_i.operation == OP_EVAL)) |=> (state_q == ST_MAC))
    else $error("evaluate transfer did not start the lanes");

  a_result_from_output_phase : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !$past(out_valid_q)) |-> $past(phase_q))
    else $error("result loaded outside the output layer");
`endif

endmodule

// ===== hw/rtl/pci_act.sv =====
// Pipelined activation unit: cubic bell, cubic S-curve or ReLU on a Q16.16 sum.
// Depends on pci_pkg.
`timescale 1ns / 1ps

module pci_act (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  pci_pkg::act_kind_e  kind_i,
  input  logic signed [31:0]  t_i,
  output logic                done_o,
  output logic signed [31:0]  result_o
);
  import pci_pkg::*;

  logic [5:0]         v_q;
  logic signed [31:0] t_q;
  act_kind_e          kind_q;
  logic               neg_q;
  logic [18:0]        u_q;
  logic [37:0]        sq_q;
  logic [56:0]        cube_q;
  logic [29:0]        vp_q;
  logic [20:0]        q_q;
  logic signed [31:0] res_q;

  logic signed [32:0] t_ext;
  logic [32:0]        abs_w;
  logic [57:0]        two_c;
  logic signed [59:0] p_s;
  logic signed [39:0] lin_s;
  logic signed [39:0] vs_s;
  logic [56:0]        sh_w;
  logic [60:0]        wneg_w;
  logic signed [62:0] w_s;
  logic signed [39:0] vb_s;
  logic [29:0]        vp_d;
  logic [60:0]        qp_w;
  logic signed [22:0] r_s;
  logic signed [31:0] clamp_s;
  logic signed [31:0] res_d;

  // magnitude of the sum, only meaningful inside the curve window
  always_comb begin
    t_ext = 33'(t_q);
    abs_w = t_q[31] ? 33'(-t_ext) : 33'(t_ext);
  end

  // curve numerator floored by 2^32 plus rounding half and divide offset
  always_comb begin
    two_c  = {cube_q, 1'b0};
    p_s    = neg_q ? $signed({2'b00, two_c}) : -$signed({2'b00, two_c});
    lin_s  = 40'(t_q) * S_SLOPE;
    vs_s   = lin_s + 40'($signed(p_s[59:32])) + CURVE_HALF + DIV_OFFSET;
    sh_w   = {sq_q, 19'd0};
    wneg_w = {sh_w, 4'd0} - {4'd0, sh_w};
    w_s    = $signed({2'b00, cube_q, 4'd0}) - $signed({2'b00, wneg_w});
    vb_s   = 40'($signed(w_s[62:32])) + CURVE_HALF + DIV_OFFSET;
    vp_d   = (kind_q == ACT_SCURVE) ? vs_s[29:0] : vb_s[29:0];
    qp_w   = 61'(vp_q) * 61'(RECIP_1000);
  end

  // final offset, clamp and window selection
  always_comb begin
    r_s = $signed({2'b00, q_q}) - DIV_BACK
          + ((kind_q == ACT_SCURVE) ? S_BASE : BELL_BASE);
    if (r_s < 23'sd0) begin
      clamp_s = 32'sd0;
    end else if (r_s > 23'sd65536) begin
      clamp_s = ONE_Q;
    end else begin
      clamp_s = 32'(r_s);
    end
    case (kind_q)
      ACT_SCURVE: begin
        if (t_q < -FIVE_Q) begin
          res_d = 32'sd0;
        end else if (t_q >= FIVE_Q) begin
          res_d = ONE_Q;
        end else begin
          res_d = clamp_s;
        end
      end
      ACT_BELL: begin
        res_d = (t_q > -FIVE_Q && t_q < FIVE_Q) ? clamp_s : 32'sd0;
      end
      ACT_RELU: begin
        res_d = t_q[31] ? 32'sd0 : t_q;
      end
      default: begin
        res_d = 32'sd0;
      end
    endcase
  end

  // stage valid chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[4:0], start_i};
    end
  end

  // datapath stages
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      t_q    <= t_i;
      kind_q <= kind_i;
    end
    if (v_q[0]) begin
      neg_q <= t_q[31];
      u_q   <= abs_w[18:0];
      sq_q  <= 38'(abs_w[18:0]) * 38'(abs_w[18:0]);
    end
    if (v_q[1]) begin
      cube_q <= 57'(sq_q) * 57'(u_q);
    end
    if (v_q[2]) begin
      vp_q <= vp_d;
    end
    if (v_q[3]) begin
      q_q <= qp_w[60:40];
    end
    if (v_q[4]) begin
      res_q <= res_d;
    end
  end

  assign done_o   = v_q[5];
  assign result_o = res_q;

endmodule

// ===== hw/rtl/pci_lane.sv =====
// One lane: a bank of the weight store, a multiply-accumulate and an activation unit.
// Depends on pci_pkg and pci_act.
`timescale 1ns / 1ps

module pci_lane (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pci_pkg::wr_req_t    wr_i,
  input  pci_pkg::mac_ctl_t   ctl_i,
  input  logic signed [31:0]  w_i,
  output logic [31:0]         rdata_o,
  input  logic                act_start_i,
  input  pci_pkg::act_kind_e  act_kind_i,
  output logic                act_done_o,
  output logic signed [31:0]  act_result_o
);
  import pci_pkg::*;

  logic [31:0]        mem_q [BANK_DEPTH];
  logic [31:0]        rdata_q;
  logic signed [31:0] x_q;
  logic               v1_q;
  logic               f1_q;
  logic               v2_q;
  logic               f2_q;
  logic signed [63:0] prod_q;
  logic signed [51:0] acc_q;
  logic signed [51:0] acc_d;
  logic signed [31:0] sat_w;

  // bank write and registered read
  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
    if (ctl_i.issue) begin
      rdata_q <= mem_q[ctl_i.rd_addr];
    end
  end

  assign rdata_o = rdata_q;

  // step valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= ctl_i.issue;
      v2_q <= v1_q;
    end
  end

  // product floored to Q16.16 and summed; the bias rides in as weight times one
  assign acc_d = (f2_q ? 52'sd0 : acc_q) + 52'(prod_q >>> 16);

  always_ff @(posedge clk_i) begin
    if (ctl_i.issue) begin
      x_q  <= ctl_i.x;
      f1_q <= ctl_i.first;
    end
    if (v1_q) begin
      prod_q <= w_i * x_q;
      f2_q   <= f1_q;
    end
    if (v2_q) begin
      acc_q <= acc_d;
    end
  end

  // saturate the sum to 32 bits
  always_comb begin
    if (acc_q > 52'sd2147483647) begin
      sat_w = 32'sh7fffffff;
    end else if (acc_q < -52'sd2147483648) begin
      sat_w = 32'sh80000000;
    end else begin
      sat_w = acc_q[31:0];
    end
  end

  pci_act u_act (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (act_start_i),
    .kind_i   (act_kind_i),
    .t_i      (sat_w),
    .done_o   (act_done_o),
    .result_o (act_result_o)
  );

endmodule
